// ===== sv/cpf_pkg.sv =====
// Shared types and constants of the checksummed packet framer.
`timescale 1ns / 1ps
`default_nettype none

package cpf_pkg;

    localparam int FRAME_LEN = 16;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = $clog2(FRAME_LEN);
    localparam int SUM_W     = 16;
    localparam int PAYLOAD_BYTES = 8;

    typedef logic [BYTE_W-1:0]                 byte_t;
    typedef logic [FRAME_LEN-1:0][BYTE_W-1:0]  frame_t;
    typedef logic [CNT_W-1:0]                  cnt_t;
    typedef logic [SUM_W-1:0]                  sum_t;

    // Frame kinds as carried on the kind field.
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;

    localparam byte_t HDR_0 = 8'hAA;
    localparam byte_t HDR_1 = 8'h55;
    localparam byte_t HDR_2 = 8'h5A;
    localparam byte_t HDR_3 = 8'hA5;
    localparam byte_t HDR_4 = 8'hBB;

    localparam byte_t TYPE_SAMPLE  = 8'h91;
    localparam byte_t TYPE_COMMAND = 8'h15;

    // Sum of the five fixed header bytes, folded at elaboration.
    localparam sum_t HDR_SUM = sum_t'(HDR_0) + sum_t'(HDR_1) + sum_t'(HDR_2)
                             + sum_t'(HDR_3) + sum_t'(HDR_4);

    // Byte positions inside a frame.
    localparam cnt_t POS_TYPE    = cnt_t'(5);
    localparam int   POS_PAYLOAD = 6;
    localparam cnt_t POS_SUM_HI  = cnt_t'(FRAME_LEN - 2);
    localparam cnt_t POS_SUM_LO  = cnt_t'(FRAME_LEN - 1);
    localparam cnt_t CNT_LAST    = cnt_t'(FRAME_LEN - 1);

    typedef struct packed {
        logic               kind;
        logic signed [31:0] sample_value;
        logic        [31:0] sample_index;
        logic        [7:0]  command_code;
        logic        [7:0]  signal_number;
        logic        [15:0] sample_rate;
        logic        [31:0] sample_count;
    } req_t;

endpackage

`default_nettype wire

// ===== sv/cpf_frame_build.sv =====
// Combinational assembly of one 16-byte frame with its checksum.
`timescale 1ns / 1ps
`default_nettype none

module cpf_frame_build (
    input  cpf_pkg::req_t   req,
    output cpf_pkg::frame_t frame
);
    import cpf_pkg::*;

    logic [PAYLOAD_BYTES*BYTE_W-1:0] payload;
    byte_t                           type_byte;
    sum_t                            sum;

    always_comb
    begin
        if (req.kind == KIND_COMMAND)
        begin
            payload   = {req.command_code, req.signal_number, req.sample_rate,
                         req.sample_count};
            type_byte = TYPE_COMMAND;
        end
        else
        begin
            payload   = {req.sample_value, req.sample_index};
            type_byte = TYPE_SAMPLE;
        end

        frame    = '0;
        frame[0] = HDR_0;
        frame[1] = HDR_1;
        frame[2] = HDR_2;
        frame[3] = HDR_3;
        frame[4] = HDR_4;
        frame[POS_TYPE] = type_byte;

        // The header part of the sum is a constant; only the type and the
        // eight payload bytes are added in logic.
        sum = HDR_SUM + sum_t'(type_byte);
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            frame[POS_PAYLOAD + i] = payload[(PAYLOAD_BYTES - i) * BYTE_W - 1 -: BYTE_W];
            sum = sum + sum_t'(payload[(PAYLOAD_BYTES - i) * BYTE_W - 1 -: BYTE_W]);
        end

        frame[POS_SUM_HI] = sum[SUM_W-1 -: BYTE_W];
        frame[POS_SUM_LO] = sum[BYTE_W-1:0];
    end

endmodule

`default_nettype wire

// ===== sv/cpf_serializer.sv =====
// Frame register, byte counter and registered byte output stage.
`timescale 1ns / 1ps
`default_nettype none

module cpf_serializer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  cpf_pkg::frame_t  frame_in,
    output logic             free,
    output logic             byte_valid,
    input  logic             byte_ready,
    output cpf_pkg::byte_t   frame_byte,
    output logic             last_byte
);
    import cpf_pkg::*;

    frame_t frame_reg;
    logic   busy_reg, busy_next;
    cnt_t   cnt_reg, cnt_next;
    logic   out_valid_reg, out_valid_next;
    byte_t  byte_reg;
    logic   last_reg;

    logic advance;
    logic at_end;
    logic emit;

    // The output register can take a new beat when it is empty or draining.
    assign advance = !out_valid_reg || byte_ready;
    assign at_end  = (cnt_reg == CNT_LAST);
    assign emit    = busy_reg && advance;
    assign free    = !busy_reg || (advance && at_end);

    always_comb
    begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;

        if (advance)
        begin
            out_valid_next = busy_reg;
        end

        if (emit)
        begin
            cnt_next = at_end ? '0 : cnt_reg + cnt_t'(1);
            if (at_end)
            begin
                busy_next = 1'b0;
            end
        end

        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= frame_in;
        end
        if (emit)
        begin
            byte_reg <= frame_reg[cnt_reg];
            last_reg <= at_end;
        end
    end

    assign byte_valid = out_valid_reg;
    assign frame_byte = byte_reg;
    assign last_byte  = last_reg;

endmodule

`default_nettype wire

// ===== sv/checksummed_packet_framer.sv =====
// Top level of the checksummed packet framer.
// Path: input register, frame register, then the registered byte output stage.
// Throughput: one frame byte per cycle while byte_ready is high; the byte counter of the
// serializer steps through the frame, and the next item waits in the input register.
// Reset: rst_n clears all valid flags and the byte counter asynchronously; no frame
// is in flight after reset.
`timescale 1ns / 1ps
`default_nettype none

module checksummed_packet_framer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic                kind,
    input  logic signed [31:0]  sample_value,
    input  logic        [31:0]  sample_index,
    input  logic        [7:0]   command_code,
    input  logic        [7:0]   signal_number,
    input  logic        [15:0]  sample_rate,
    input  logic        [31:0]  sample_count,
    output logic                byte_valid,
    input  logic                byte_ready,
    output cpf_pkg::byte_t      frame_byte,
    output logic                last_byte
);
    import cpf_pkg::*;

    req_t   req_reg;
    logic   req_valid_reg, req_valid_next;
    frame_t frame;
    logic   free;
    logic   load;
    logic   accept;

    assign item_ready = !req_valid_reg || free;
    assign accept     = item_valid && item_ready;
    assign load       = req_valid_reg && free;

    always_comb
    begin
        req_valid_next = accept || (req_valid_reg && !free);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.kind          <= kind;
            req_reg.sample_value  <= sample_value;
            req_reg.sample_index  <= sample_index;
            req_reg.command_code  <= command_code;
            req_reg.signal_number <= signal_number;
            req_reg.sample_rate   <= sample_rate;
            req_reg.sample_count  <= sample_count;
        end
    end

    cpf_frame_build u_build (
        .req   (req_reg),
        .frame (frame)
    );

    cpf_serializer u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .frame_in   (frame),
        .free       (free),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .frame_byte (frame_byte),
        .last_byte  (last_byte)
    );

endmodule

`default_nettype wire

// ===== sv/cpf_checker.sv =====
// Port-level checks of the framer output stream, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cpf_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    input  logic            byte_ready,
    input  cpf_pkg::byte_t  frame_byte,
    input  logic            last_byte
);
    import cpf_pkg::*;

    cnt_t beat_cnt_reg, beat_cnt_next;
    sum_t sum_reg, sum_next;
    logic beat;

    assign beat = byte_valid && byte_ready;

    always_comb
    begin
        beat_cnt_next = beat_cnt_reg;
        sum_next      = sum_reg;
        if (beat)
        begin
            beat_cnt_next = (beat_cnt_reg == CNT_LAST) ? '0 : beat_cnt_reg + cnt_t'(1);
            sum_next      = (beat_cnt_reg == CNT_LAST) ? '0
                                                       : sum_reg + sum_t'(frame_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_cnt_reg <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            beat_cnt_reg <= beat_cnt_next;
            sum_reg      <= sum_next;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_ready |=>
            byte_valid && $stable(frame_byte) && $stable(last_byte))
        else $error("stalled output beat changed");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid |-> (last_byte == (beat_cnt_reg == CNT_LAST)))
        else $error("last marker not on the sixteenth beat");

    a_type: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && beat_cnt_reg == POS_TYPE |->
            frame_byte == TYPE_SAMPLE || frame_byte == TYPE_COMMAND)
        else $error("bad frame type byte");

    a_sum: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && beat_cnt_reg == POS_SUM_HI |->
            frame_byte == sum_reg[SUM_W-1 -: BYTE_W])
        else $error("checksum high byte mismatch");

endmodule

bind checksummed_packet_framer cpf_checker u_cpf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .frame_byte (frame_byte),
    .last_byte  (last_byte)
);

`default_nettype wire
